// ----- rtl/tee_pkg.sv -----
// Shared types and constants for the text escape encoder.
package tee_pkg;

   // Escaping scheme selected by the mode register
   typedef enum logic [1:0] {
      MODE_NTRIPLES = 2'd0,
      MODE_JSON     = 2'd1,
      MODE_XML      = 2'd2,
      MODE_COPY     = 2'd3
   } escape_mode_type;

   // Longest escape sequence (JSON \u00XX) and the index width that covers it
   localparam int MAX_SEQ = 6;
   localparam int IDX_W   = $clog2(MAX_SEQ);

   // One output symbol from the lookup to the result register
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } sym_type;

endpackage

// ----- rtl/tee_req_if.sv -----
// Request channel: one raw text byte per transfer.
interface tee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/tee_rsp_if.sv -----
// Response channel: one escaped byte per transfer, last flags end of sequence.
interface tee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ----- rtl/tee_lookup.sv -----
// Escape table lookup: picks one byte of the escape sequence for a held byte.
module tee_lookup (
   input  tee_pkg::escape_mode_type   mode,
   input  logic [7:0]                 raw_byte,
   input  logic [tee_pkg::IDX_W-1:0]  idx,
   output tee_pkg::sym_type           sym
);

   localparam logic [7:0] CH_BSL  = 8'h5C;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_FF   = 8'h0C;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   // lowercase hex digit for one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return {4'h3, nib};
      end
      return 8'h57 + {4'h0, nib};
   endfunction

   logic [7:0]               seq [tee_pkg::MAX_SEQ];
   logic [tee_pkg::IDX_W-1:0] seq_len;

   // backslash pair helper
   function automatic logic [7:0] pair_char(input logic [7:0] b);
      case (b)
         CH_NL:   return 8'h6E;  // n
         CH_CR:   return 8'h72;  // r
         CH_TAB:  return 8'h74;  // t
         CH_BS:   return 8'h62;  // b
         CH_FF:   return 8'h66;  // f
         default: return b;      // quote and backslash stand as themselves
      endcase
   endfunction

   // build the full sequence for the held byte
   always_comb begin
      for (int k = 0; k < tee_pkg::MAX_SEQ; k++) begin
         seq[k] = raw_byte;
      end
      seq_len = tee_pkg::IDX_W'(1);
      unique case (mode)
         tee_pkg::MODE_NTRIPLES: begin
            case (raw_byte)
               CH_NL, CH_CR, CH_TAB, CH_QUOT, CH_BSL: begin
                  seq[0]  = CH_BSL;
                  seq[1]  = pair_char(raw_byte);
                  seq_len = tee_pkg::IDX_W'(2);
               end
               default: ;
            endcase
         end
         tee_pkg::MODE_JSON: begin
            case (raw_byte)
               CH_NL, CH_CR, CH_TAB, CH_BS, CH_FF, CH_QUOT, CH_BSL: begin
                  seq[0]  = CH_BSL;
                  seq[1]  = pair_char(raw_byte);
                  seq_len = tee_pkg::IDX_W'(2);
               end
               default: begin
                  // other control bytes: \u00 and two hex digits
                  if (raw_byte < 8'h20) begin
                     seq[0]  = CH_BSL;
                     seq[1]  = 8'h75;  // u
                     seq[2]  = 8'h30;
                     seq[3]  = 8'h30;
                     seq[4]  = hex_digit(raw_byte[7:4]);
                     seq[5]  = hex_digit(raw_byte[3:0]);
                     seq_len = tee_pkg::IDX_W'(6);
                  end
               end
            endcase
         end
         tee_pkg::MODE_XML: begin
            case (raw_byte)
               CH_LT: begin
                  seq[0] = CH_AMP; seq[1] = 8'h6C; seq[2] = 8'h74; seq[3] = CH_SEMI;
                  seq_len = tee_pkg::IDX_W'(4);
               end
               CH_GT: begin
                  seq[0] = CH_AMP; seq[1] = 8'h67; seq[2] = 8'h74; seq[3] = CH_SEMI;
                  seq_len = tee_pkg::IDX_W'(4);
               end
               CH_AMP: begin
                  seq[0] = CH_AMP; seq[1] = 8'h61; seq[2] = 8'h6D; seq[3] = 8'h70;
                  seq[4] = CH_SEMI;
                  seq_len = tee_pkg::IDX_W'(5);
               end
               CH_QUOT: begin
                  seq[0] = CH_AMP; seq[1] = 8'h71; seq[2] = 8'h75; seq[3] = 8'h6F;
                  seq[4] = 8'h74;  seq[5] = CH_SEMI;
                  seq_len = tee_pkg::IDX_W'(6);
               end
               CH_APOS: begin
                  seq[0] = CH_AMP; seq[1] = 8'h61; seq[2] = 8'h70; seq[3] = 8'h6F;
                  seq[4] = 8'h73;  seq[5] = CH_SEMI;
                  seq_len = tee_pkg::IDX_W'(6);
               end
               default: ;
            endcase
         end
         tee_pkg::MODE_COPY: ;
      endcase
   end

   // select the symbol at the current position
   assign sym.out_byte = seq[idx];
   assign sym.last     = (idx == seq_len - tee_pkg::IDX_W'(1));

endmodule

// ----- rtl/text_escape_encoder.sv -----
// Top level of the text escape encoder: holding register, lookup, result register.
//
// Usage:
//   req_ch carries one raw text byte per request; rsp_ch returns the escaped
//   sequence one byte per transfer, with last high on its final byte.
//   csr_wr_en/csr_wr_data write the 2-bit escape mode (N-Triples, JSON, XML,
//   copy); write it only while no request is in flight.
// A taken byte is held first; its escaped bytes then reach the result register.
// Throughput: one output byte per cycle while rsp_ch.ready is high. A byte that
//   escapes to N bytes occupies the holding register until all N have moved
//   out, so an unescaped stream runs at one request per cycle and expanded
//   bytes stall req_ch while the extra bytes drain. The next request is taken
//   in the cycle its predecessor's final byte moves into the result register.
// Reset: synchronous, clears the mode to N-Triples and empties both registers.
// Stall: while rsp_ch.ready is low the result register holds its byte, the
//   holding register stops advancing and req_ch.ready drops once it is full.
module text_escape_encoder (
   input  logic          clock,
   input  logic          reset,
   tee_req_if.sink       req_ch,
   tee_rsp_if.source     rsp_ch,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_wr_data
);

   tee_pkg::escape_mode_type  mode_ff;
   logic [7:0]                byte_ff;
   logic [tee_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      hold_valid_ff, hold_valid_in;
   logic [7:0]                out_byte_ff;
   logic                      out_last_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   tee_pkg::sym_type          sym;
   logic                      out_free, advance, take;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tee_pkg::MODE_NTRIPLES;
      end else if (csr_wr_en) begin
         mode_ff <= tee_pkg::escape_mode_type'(csr_wr_data);
      end
   end

   tee_lookup u_lookup (
      .mode     (mode_ff),
      .raw_byte (byte_ff),
      .idx      (idx_ff),
      .sym      (sym)
   );

   // handshake control
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = hold_valid_ff && out_free;
   assign req_ch.ready = !hold_valid_ff || (advance && sym.last);
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         idx_in        = '0;
      end else if (advance) begin
         if (sym.last) begin
            hold_valid_in = 1'b0;
         end
         idx_in = idx_ff + tee_pkg::IDX_W'(1);
      end
      rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   // holding register and result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_ch.in_byte;
      end
      if (advance) begin
         out_byte_ff <= sym.out_byte;
         out_last_ff <= sym.last;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.last     = out_last_ff;

   // position never runs past the longest sequence
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (idx_ff < tee_pkg::IDX_W'(tee_pkg::MAX_SEQ)))
      else $error("escape index out of range");

   // a new request starts at the first position of its sequence
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      take |=> (hold_valid_ff && idx_ff == '0))
      else $error("request did not start at position zero");

   // a mid-sequence byte keeps the holding register busy
   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && !sym.last) |=> (hold_valid_ff && idx_ff != '0))
      else $error("holding register released before sequence end");

   // every byte moved out reaches the response register
   a_adv_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ch.valid && rsp_ch.last == $past(sym.last)))
      else $error("response register not loaded");

endmodule
